// ===== src/rgb_hsv_color_converter_macros.svh =====
`ifndef RGB_HSV_COLOR_CONVERTER_MACROS_SVH
`define RGB_HSV_COLOR_CONVERTER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RHC_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> post) \
    else $error("implication check failed");

`define RHC_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define RHC_ASSERT_IMP(name, pre, post)

`define RHC_ASSERT_NEVER(name, cond)

`endif

`endif

// ===== src/rhc_pkg.sv =====
package rhc_pkg;

  localparam logic [7:0] FULL     = 8'd255;
  localparam logic [7:0] HUE_STEP = 8'd43;
  localparam logic [7:0] BASE_R   = 8'd0;
  localparam logic [7:0] BASE_G   = 8'd85;
  localparam logic [7:0] BASE_B   = 8'd171;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sec_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
  } hsv_t;

  function automatic logic [7:0] sector_start(sec_e sec);
    logic [7:0] start;
    unique case (sec)
      SEC_RY:  start = 8'd0;
      SEC_YG:  start = HUE_STEP;
      SEC_GC:  start = 8'(2 * HUE_STEP);
      SEC_CB:  start = 8'(3 * HUE_STEP);
      SEC_BM:  start = 8'(4 * HUE_STEP);
      SEC_MR:  start = 8'(5 * HUE_STEP);
      default: start = 8'd0;
    endcase
    return start;
  endfunction

  function automatic sec_e hue_sector(logic [7:0] hue);
    sec_e sec;
    priority if (hue >= sector_start(SEC_MR)) begin
      sec = SEC_MR;
    end else if (hue >= sector_start(SEC_BM)) begin
      sec = SEC_BM;
    end else if (hue >= sector_start(SEC_CB)) begin
      sec = SEC_CB;
    end else if (hue >= sector_start(SEC_GC)) begin
      sec = SEC_GC;
    end else if (hue >= sector_start(SEC_YG)) begin
      sec = SEC_YG;
    end else begin
      sec = SEC_RY;
    end
    return sec;
  endfunction

endpackage

// ===== src/rgb_hsv_color_converter.sv =====
// Converts one 8-bit color triple per transfer, in either direction.
// An item is taken at a rising clock edge with start_i high and busy_o low.
// op_i low reads the inputs as hue, saturation and value and returns red,
// green and blue; op_i high reads red, green and blue and returns hue,
// saturation and value.
// busy_o is always low: a new item can enter on every clock cycle.
// The result is driven from the output register on the three output fields,
// for exactly one cycle with done_o high, and is taken at the edge that ends
// that cycle. Results leave in the order in which the items came in.
// The RGB to HSV path is deeper: one stage for the channel maximum and
// minimum, one for the scaled numerators, four restoring divider stages
// (two saturation and, in the first three, two hue quotient bits each), the
// output register. The HSV to RGB path takes three stages, delayed to match.
// Throughput is one item per clock cycle.
// The receiver cannot stall the block, so every result is offered once.
// Reset clears the valid pipeline; items in flight are dropped and no
// done_o pulse follows until new items are accepted.
`include "rgb_hsv_color_converter_macros.svh"

module rgb_hsv_color_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       op_i,
  input  logic [7:0] first_in_i,
  input  logic [7:0] second_in_i,
  input  logic [7:0] third_in_i,
  output logic       done_o,
  output logic [7:0] first_out_o,
  output logic [7:0] second_out_o,
  output logic [7:0] third_out_o
);

  rhc_pkg::rgb_t rgb_res;
  rhc_pkg::hsv_t hsv_res;
  rhc_pkg::rgb_t rgb_dly_q [3];
  logic [6:0]    vld_q;
  logic [5:0]    op_q;
  logic [7:0]    first_out_d, second_out_d, third_out_d;
  logic [7:0]    first_out_q, second_out_q, third_out_q;

  assign busy_o = 1'b0;

  rhc_hsv u_hsv (
    .clk_i (clk_i),
    .hue_i (first_in_i),
    .sat_i (second_in_i),
    .val_i (third_in_i),
    .rgb_o (rgb_res)
  );

  rhc_rgb u_rgb (
    .clk_i   (clk_i),
    .red_i   (first_in_i),
    .green_i (second_in_i),
    .blue_i  (third_in_i),
    .hsv_o   (hsv_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      op_q  <= '0;
    end else begin
      vld_q <= {vld_q[5:0], start_i && !busy_o};
      op_q  <= {op_q[4:0], op_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rgb_dly_q[0] <= rgb_res;
    rgb_dly_q[1] <= rgb_dly_q[0];
    rgb_dly_q[2] <= rgb_dly_q[1];
  end

  always_comb begin
    if (op_q[5]) begin
      first_out_d  = hsv_res.h;
      second_out_d = hsv_res.s;
      third_out_d  = hsv_res.v;
    end else begin
      first_out_d  = rgb_dly_q[2].r;
      second_out_d = rgb_dly_q[2].g;
      third_out_d  = rgb_dly_q[2].b;
    end
  end

  always_ff @(posedge clk_i) begin
    first_out_q  <= first_out_d;
    second_out_q <= second_out_d;
    third_out_q  <= third_out_d;
  end

  assign done_o       = vld_q[6];
  assign first_out_o  = first_out_q;
  assign second_out_o = second_out_q;
  assign third_out_o  = third_out_q;

  `RHC_ASSERT_IMP(a_done_latency, start_i && !busy_o, ##7 done_o)
  `RHC_ASSERT_IMP(a_done_origin, done_o, $past(start_i && !busy_o, 7))
  `RHC_ASSERT_IMP(a_grey_hue, done_o && $past(op_i, 7) && second_out_o == 8'd0, first_out_o == 8'd0)
  `RHC_ASSERT_IMP(a_value_max, done_o && $past(op_i, 7), third_out_o >= $past(first_in_i, 7) && third_out_o >= $past(second_in_i, 7) && third_out_o >= $past(third_in_i, 7))
  `RHC_ASSERT_NEVER(a_black_sat, done_o && $past(op_i, 7) && third_out_o == 8'd0 && second_out_o != 8'd0)

endmodule

// ===== src/rhc_hsv.sv =====
module rhc_hsv (
  input  logic          clk_i,
  input  logic [7:0]    hue_i,
  input  logic [7:0]    sat_i,
  input  logic [7:0]    val_i,
  output rhc_pkg::rgb_t rgb_o
);

  rhc_pkg::sec_e sec1_d, sec1_q, sec2_q, sec3_q;
  logic [7:0]    off1;
  logic [7:0]    rem1_d, rem1_q;
  logic [7:0]    sat1_q;
  logic [7:0]    val1_q, val2_q, val3_q;
  logic          grey1_q, grey2_q, grey3_q;
  logic [15:0]   pp2_d, pq2_d, pt2_d;
  logic [15:0]   pp2_q, pq2_q, pt2_q;
  logic [15:0]   qq3_d, tq3_d;
  logic [15:0]   qq3_q, tq3_q;
  logic [7:0]    p3_q;
  logic [7:0]    p_val, q_val, t_val;

  always_comb begin
    sec1_d = rhc_pkg::hue_sector(hue_i);
    off1   = hue_i - rhc_pkg::sector_start(sec1_d);
    rem1_d = {off1[5:0], 2'b00} + {1'b0, off1[5:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    sec1_q  <= sec1_d;
    rem1_q  <= rem1_d;
    sat1_q  <= sat_i;
    val1_q  <= val_i;
    grey1_q <= (sat_i == 8'd0);
  end

  always_comb begin
    pp2_d = 16'(val1_q) * 16'(rhc_pkg::FULL - sat1_q);
    pq2_d = 16'(sat1_q) * 16'(rem1_q);
    pt2_d = 16'(sat1_q) * 16'(rhc_pkg::FULL - rem1_q);
  end

  always_ff @(posedge clk_i) begin
    sec2_q  <= sec1_q;
    val2_q  <= val1_q;
    grey2_q <= grey1_q;
    pp2_q   <= pp2_d;
    pq2_q   <= pq2_d;
    pt2_q   <= pt2_d;
  end

  always_comb begin
    qq3_d = 16'(val2_q) * 16'(rhc_pkg::FULL - pq2_q[15:8]);
    tq3_d = 16'(val2_q) * 16'(rhc_pkg::FULL - pt2_q[15:8]);
  end

  always_ff @(posedge clk_i) begin
    sec3_q  <= sec2_q;
    val3_q  <= val2_q;
    grey3_q <= grey2_q;
    p3_q    <= pp2_q[15:8];
    qq3_q   <= qq3_d;
    tq3_q   <= tq3_d;
  end

  always_comb begin
    p_val = p3_q;
    q_val = qq3_q[15:8];
    t_val = tq3_q[15:8];
    if (grey3_q) begin
      rgb_o = '{r: val3_q, g: val3_q, b: val3_q};
    end else begin
      unique case (sec3_q)
        rhc_pkg::SEC_RY: rgb_o = '{r: val3_q, g: t_val,  b: p_val};
        rhc_pkg::SEC_YG: rgb_o = '{r: q_val,  g: val3_q, b: p_val};
        rhc_pkg::SEC_GC: rgb_o = '{r: p_val,  g: val3_q, b: t_val};
        rhc_pkg::SEC_CB: rgb_o = '{r: p_val,  g: q_val,  b: val3_q};
        rhc_pkg::SEC_BM: rgb_o = '{r: t_val,  g: p_val,  b: val3_q};
        default:         rgb_o = '{r: val3_q, g: p_val,  b: q_val};
      endcase
    end
  end

endmodule

// ===== src/rhc_rgb.sv =====
module rhc_rgb (
  input  logic          clk_i,
  input  logic [7:0]    red_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    blue_i,
  output rhc_pkg::hsv_t hsv_o
);

  typedef struct packed {
    logic [15:0] rs;
    logic [13:0] rh;
    logic [7:0]  qs;
    logic [5:0]  qh;
    logic [7:0]  mx;
    logic [7:0]  dd;
    logic        neg;
    logic [7:0]  base;
  } div_t;

  logic       r_top, g_top;
  logic [7:0] mx1_d, mn1, min_rg, na1, nb1, base1_d;
  logic       neg1_d;
  logic [7:0] mag1_d;
  logic [7:0] mx1_q, d1_q, mag1_q, base1_q;
  logic       neg1_q;
  div_t       dv0_d;
  div_t       dv_q [5];
  div_t       fin;
  logic [7:0] quo8;

  always_comb begin
    r_top  = (red_i >= green_i) && (red_i >= blue_i);
    g_top  = (green_i >= blue_i);
    min_rg = (red_i < green_i) ? red_i : green_i;
    mn1    = (min_rg < blue_i) ? min_rg : blue_i;
    priority if (r_top) begin
      mx1_d   = red_i;
      na1     = green_i;
      nb1     = blue_i;
      base1_d = rhc_pkg::BASE_R;
    end else if (g_top) begin
      mx1_d   = green_i;
      na1     = blue_i;
      nb1     = red_i;
      base1_d = rhc_pkg::BASE_G;
    end else begin
      mx1_d   = blue_i;
      na1     = red_i;
      nb1     = green_i;
      base1_d = rhc_pkg::BASE_B;
    end
    neg1_d = (na1 < nb1);
    mag1_d = neg1_d ? (nb1 - na1) : (na1 - nb1);
  end

  always_ff @(posedge clk_i) begin
    mx1_q   <= mx1_d;
    d1_q    <= mx1_d - mn1;
    neg1_q  <= neg1_d;
    mag1_q  <= mag1_d;
    base1_q <= base1_d;
  end

  always_comb begin
    dv0_d.rs   = 16'(d1_q) * 16'(rhc_pkg::FULL);
    dv0_d.rh   = 14'(mag1_q) * 14'(rhc_pkg::HUE_STEP);
    dv0_d.qs   = '0;
    dv0_d.qh   = '0;
    dv0_d.mx   = mx1_q;
    dv0_d.dd   = d1_q;
    dv0_d.neg  = neg1_q;
    dv0_d.base = base1_q;
  end

  always_ff @(posedge clk_i) begin
    dv_q[0] <= dv0_d;
  end

  // Each stage retires two saturation quotient bits; the first three also two hue bits.
  for (genvar k = 0; k < 4; k++) begin : g_div
    localparam int SatBit = 7 - 2 * k;
    localparam int HueBit = 5 - 2 * k;
    div_t stg_d;

    always_comb begin
      logic [15:0] tr_s;
      logic [13:0] tr_h;
      stg_d = dv_q[k];
      tr_s  = '0;
      tr_h  = '0;
      for (int j = 0; j < 2; j++) begin
        tr_s = 16'(stg_d.mx) << (SatBit - j);
        if (stg_d.rs >= tr_s) begin
          stg_d.rs = stg_d.rs - tr_s;
          stg_d.qs = {stg_d.qs[6:0], 1'b1};
        end else begin
          stg_d.qs = {stg_d.qs[6:0], 1'b0};
        end
        if (k < 3) begin
          tr_h = 14'(stg_d.dd) << (HueBit - j);
          if (stg_d.rh >= tr_h) begin
            stg_d.rh = stg_d.rh - tr_h;
            stg_d.qh = {stg_d.qh[4:0], 1'b1};
          end else begin
            stg_d.qh = {stg_d.qh[4:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[k+1] <= stg_d;
    end
  end

  always_comb begin
    fin     = dv_q[4];
    quo8    = {2'b00, fin.qh};
    hsv_o.v = fin.mx;
    if (fin.dd == 8'd0) begin
      hsv_o.h = 8'd0;
      hsv_o.s = 8'd0;
    end else begin
      hsv_o.h = fin.neg ? (fin.base - quo8) : (fin.base + quo8);
      hsv_o.s = fin.qs;
    end
  end

endmodule

// ===== verif/tb_rgb_hsv_color_converter.sv =====
`timescale 1ns / 100ps

module tb_rgb_hsv_color_converter;

  localparam logic OP_HSV_TO_RGB = 1'b0;
  localparam logic OP_RGB_TO_HSV = 1'b1;
  localparam int unsigned IDLE_PCT = 22;
  localparam int NUM_RANDOM = 450;
  localparam int NUM_DIRECTED = 25;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
  } color_t;

  typedef struct packed {
    logic       op;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic       known;
    color_t     value;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic       op_i;
  logic [7:0] first_in_i;
  logic [7:0] second_in_i;
  logic [7:0] third_in_i;
  logic       done_o;
  logic [7:0] first_out_o;
  logic [7:0] second_out_o;
  logic [7:0] third_out_o;

  logic       row_known;
  color_t     row_expect;
  color_t     pending_colors[$];
  int         fail_count = 0;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_HSV_TO_RGB, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{OP_HSV_TO_RGB, 8'd123, 8'd0,   8'd200, 1'b1, '{8'd200, 8'd200, 8'd200}},
    '{OP_HSV_TO_RGB, 8'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{OP_HSV_TO_RGB, 8'd255, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{OP_HSV_TO_RGB, 8'd255, 8'd255, 8'd255, 1'b0, '0},
    '{OP_HSV_TO_RGB, 8'd42,  8'd200, 8'd180, 1'b0, '0},
    '{OP_HSV_TO_RGB, 8'd43,  8'd200, 8'd180, 1'b0, '0},
    '{OP_HSV_TO_RGB, 8'd85,  8'd128, 8'd255, 1'b0, '0},
    '{OP_HSV_TO_RGB, 8'd86,  8'd128, 8'd255, 1'b0, '0},
    '{OP_HSV_TO_RGB, 8'd128, 8'd255, 8'd100, 1'b0, '0},
    '{OP_HSV_TO_RGB, 8'd129, 8'd1,   8'd255, 1'b0, '0},
    '{OP_HSV_TO_RGB, 8'd171, 8'd77,  8'd220, 1'b0, '0},
    '{OP_HSV_TO_RGB, 8'd172, 8'd255, 8'd255, 1'b0, '0},
    '{OP_HSV_TO_RGB, 8'd214, 8'd255, 8'd255, 1'b0, '0},
    '{OP_HSV_TO_RGB, 8'd215, 8'd255, 8'd255, 1'b0, '0},
    '{OP_RGB_TO_HSV, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{OP_RGB_TO_HSV, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{OP_RGB_TO_HSV, 8'd100, 8'd100, 8'd100, 1'b1, '{8'd0,   8'd0,   8'd100}},
    '{OP_RGB_TO_HSV, 8'd255, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd255}},
    '{OP_RGB_TO_HSV, 8'd0,   8'd255, 8'd0,   1'b1, '{8'd85,  8'd255, 8'd255}},
    '{OP_RGB_TO_HSV, 8'd0,   8'd0,   8'd255, 1'b1, '{8'd171, 8'd255, 8'd255}},
    '{OP_RGB_TO_HSV, 8'd255, 8'd0,   8'd10,  1'b0, '0},
    '{OP_RGB_TO_HSV, 8'd200, 8'd200, 8'd50,  1'b0, '0},
    '{OP_RGB_TO_HSV, 8'd50,  8'd200, 8'd200, 1'b0, '0},
    '{OP_RGB_TO_HSV, 8'd200, 8'd50,  8'd200, 1'b0, '0}
  };

  rgb_hsv_color_converter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .op_i        (op_i),
    .first_in_i  (first_in_i),
    .second_in_i (second_in_i),
    .third_in_i  (third_in_i),
    .done_o      (done_o),
    .first_out_o (first_out_o),
    .second_out_o(second_out_o),
    .third_out_o (third_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic color_t predict_rgb(logic [7:0] hue, logic [7:0] sat, logic [7:0] val);
    int h, s, v, full, step, region, frac, p, q, t, r, g, b;
    rhc_pkg::sec_e sector;
    h = hue;
    s = sat;
    v = val;
    full = rhc_pkg::FULL;
    step = rhc_pkg::HUE_STEP;
    if (s == 0) begin
      return '{val, val, val};
    end
    region = h / step;
    frac = (h - region * step) * 6;
    p = (v * (full - s)) >> 8;
    q = (v * (full - ((s * frac) >> 8))) >> 8;
    t = (v * (full - ((s * (full - frac)) >> 8))) >> 8;
    sector = rhc_pkg::sec_e'(region);
    case (sector)
      rhc_pkg::SEC_RY: begin r = v; g = t; b = p; end
      rhc_pkg::SEC_YG: begin r = q; g = v; b = p; end
      rhc_pkg::SEC_GC: begin r = p; g = v; b = t; end
      rhc_pkg::SEC_CB: begin r = p; g = q; b = v; end
      rhc_pkg::SEC_BM: begin r = t; g = p; b = v; end
      default: begin r = v; g = p; b = q; end
    endcase
    return '{8'(r), 8'(g), 8'(b)};
  endfunction

  function automatic color_t predict_hsv(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    int r, g, b, mx, mn, d, s, base, num, hue;
    r = red;
    g = green;
    b = blue;
    mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    if (mx == 0) begin
      return '0;
    end
    d = mx - mn;
    s = (int'(rhc_pkg::FULL) * d) / mx;
    if (s == 0) begin
      return '{8'd0, 8'(s), 8'(mx)};
    end
    if (mx == r) begin
      base = rhc_pkg::BASE_R;
      num = g - b;
    end else if (mx == g) begin
      base = rhc_pkg::BASE_G;
      num = b - r;
    end else begin
      base = rhc_pkg::BASE_B;
      num = r - g;
    end
    // Signed division truncates toward zero; the cast wraps a negative hue.
    hue = base + (int'(rhc_pkg::HUE_STEP) * num) / d;
    return '{8'(hue), 8'(s), 8'(mx)};
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    color_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_colors.size() == 0) begin
          report_mismatch("result with no transfer pending", first_out_o, 8'd0);
        end else begin
          want = pending_colors.pop_front();
          if (first_out_o !== want.first) begin
            report_mismatch("first_out", first_out_o, want.first);
          end
          if (second_out_o !== want.second) begin
            report_mismatch("second_out", second_out_o, want.second);
          end
          if (third_out_o !== want.third) begin
            report_mismatch("third_out", third_out_o, want.third);
          end
        end
      end
      if (start_i && !busy_o) begin
        if (row_known) begin
          pending_colors.push_back(row_expect);
        end else if (op_i == OP_HSV_TO_RGB) begin
          pending_colors.push_back(predict_rgb(first_in_i, second_in_i, third_in_i));
        end else begin
          pending_colors.push_back(predict_hsv(first_in_i, second_in_i, third_in_i));
        end
      end
    end
  end

  task automatic send_item(input logic op, input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] c, input logic known, input color_t value,
                           input logic may_idle);
    logic stalled;
    while (may_idle && $urandom_range(99) < IDLE_PCT) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    op_i        <= op;
    first_in_i  <= a;
    second_in_i <= b;
    third_in_i  <= c;
    row_known   <= known;
    row_expect  <= value;
    do begin
      @(negedge clk_i);
      stalled = busy_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  task automatic drain_pending();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending_colors.size() != 0) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
  endtask

  task automatic pick_random_item(output logic op, output logic [7:0] a,
                                  output logic [7:0] b, output logic [7:0] c);
    int unsigned kind;
    logic [7:0] top;
    kind = $urandom_range(99);
    op = 1'($urandom);
    a = 8'($urandom);
    b = 8'($urandom);
    c = 8'($urandom);
    top = 8'($urandom_range(255, 1));
    if (kind < 55) begin
      return;
    end else if (kind < 65) begin
      op = OP_HSV_TO_RGB;
      b = 8'd0;
    end else if (kind < 75) begin
      op = OP_RGB_TO_HSV;
      b = a;
      c = a;
    end else if (kind < 85) begin
      op = OP_RGB_TO_HSV;
      case ($urandom_range(2))
        0: begin a = top; b = top; c = 8'($urandom_range(top)); end
        1: begin b = top; c = top; a = 8'($urandom_range(top)); end
        default: begin a = top; c = top; b = 8'($urandom_range(top)); end
      endcase
    end else if (kind < 92) begin
      op = OP_HSV_TO_RGB;
      a = 8'(int'(rhc_pkg::HUE_STEP) * $urandom_range(5) + $urandom_range(2) - 1);
    end else begin
      op = OP_RGB_TO_HSV;
      case ($urandom_range(2))
        0: begin a = 8'd255; b = 8'd0; end
        1: begin b = 8'd255; c = 8'd0; end
        default: begin c = 8'd255; a = 8'd0; end
      endcase
    end
  endtask

  initial begin
    logic       op;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    op_i        <= OP_HSV_TO_RGB;
    first_in_i  <= 8'd0;
    second_in_i <= 8'd0;
    third_in_i  <= 8'd0;
    row_known   <= 1'b0;
    row_expect  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].c, directed_rows[i].known, directed_rows[i].value, 1'b1);
    end
    drain_pending();

    // Items 150 to 249 go back to back to keep the pipeline full.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      pick_random_item(op, a, b, c);
      send_item(op, a, b, c, 1'b0, '0, (n < 150) || (n >= 250));
      if (n == 300) begin
        drain_pending();
      end
    end
    drain_pending();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/rhc_pkg.sv
src/rhc_hsv.sv
src/rhc_rgb.sv
src/rgb_hsv_color_converter.sv
verif/tb_rgb_hsv_color_converter.sv
